/* sv/wsfd_pkg.sv */
// ---------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ---------------------------------------------------------------------------
package wsfd_pkg;

  // Length codes of the second header byte that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Last byte index of each multi-byte header field
  localparam logic [2:0] LEN16_LAST = 3'd1;
  localparam logic [2:0] LEN64_LAST = 3'd7;
  localparam logic [2:0] MASK_LAST  = 3'd3;

  typedef enum logic [5:0] {
    PH_HDR1  = 6'b000001,
    PH_HDR2  = 6'b000010,
    PH_LEN16 = 6'b000100,
    PH_LEN64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       frame_end;
    logic       empty_frame;
  } result_t;

endpackage

/* sv/wsfd_parser.sv */
// ---------------------------------------------------------------------------
// wsfd_parser
// Byte-wise frame header parser and payload unmasker; one byte per advance.
// ---------------------------------------------------------------------------
module wsfd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  output wsfd_pkg::result_t res
);

  wsfd_pkg::phase_t phase, phase_next;
  logic [2:0]  field_count, field_count_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [63:0] remaining, remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_idx, key_idx_next;

  always_comb begin
    logic       len_done;
    logic       start;
    logic [7:0] key_byte;

    len_done         = 1'b0;
    start            = 1'b0;
    key_byte         = 8'd0;
    phase_next       = phase;
    field_count_next = field_count;
    fin_flag_next    = fin_flag;
    opcode_next      = opcode;
    masked_next      = masked;
    remaining_next   = remaining;
    mask_key_next    = mask_key;
    key_idx_next     = key_idx;
    res              = '0;
    res.frame_opcode   = opcode;
    res.final_fragment = fin_flag;

    unique case (phase)
      wsfd_pkg::PH_HDR2: begin
        masked_next      = rx_byte[7];
        field_count_next = 3'd0;
        remaining_next   = 64'd0;
        if (rx_byte[6:0] == wsfd_pkg::LEN_CODE_16) begin
          phase_next = wsfd_pkg::PH_LEN16;
        end else if (rx_byte[6:0] == wsfd_pkg::LEN_CODE_64) begin
          phase_next = wsfd_pkg::PH_LEN64;
        end else begin
          remaining_next = {57'd0, rx_byte[6:0]};
          len_done       = 1'b1;
        end
      end
      wsfd_pkg::PH_LEN16: begin
        remaining_next = {remaining[55:0], rx_byte};
        if (field_count >= wsfd_pkg::LEN16_LAST) begin
          len_done = 1'b1;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      wsfd_pkg::PH_LEN64: begin
        remaining_next = {remaining[55:0], rx_byte};
        if (field_count >= wsfd_pkg::LEN64_LAST) begin
          len_done = 1'b1;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      wsfd_pkg::PH_MASK: begin
        mask_key_next = {mask_key[23:0], rx_byte};
        if (field_count >= wsfd_pkg::MASK_LAST) begin
          field_count_next = 3'd0;
          start            = 1'b1;
        end else begin
          field_count_next = field_count + 3'd1;
        end
      end
      wsfd_pkg::PH_DATA: begin
        // First key byte received sits in the top byte of the key
        if (masked) begin
          unique case (key_idx)
            2'd0: key_byte = mask_key[31:24];
            2'd1: key_byte = mask_key[23:16];
            2'd2: key_byte = mask_key[15:8];
            2'd3: key_byte = mask_key[7:0];
          endcase
        end
        res.valid        = 1'b1;
        res.payload_byte = rx_byte ^ key_byte;
        res.frame_end    = (remaining == 64'd1);
        remaining_next   = remaining - 64'd1;
        key_idx_next     = key_idx + 2'd1;
        if (remaining == 64'd1) begin
          phase_next = wsfd_pkg::PH_HDR1;
        end
      end
      default: begin
        // First header byte: FIN and opcode, clear the frame context
        fin_flag_next    = rx_byte[7];
        opcode_next      = rx_byte[3:0];
        masked_next      = 1'b0;
        remaining_next   = 64'd0;
        mask_key_next    = 32'd0;
        field_count_next = 3'd0;
        phase_next       = wsfd_pkg::PH_HDR2;
      end
    endcase

    if (len_done) begin
      field_count_next = 3'd0;
      if (masked_next) begin
        phase_next = wsfd_pkg::PH_MASK;
      end else begin
        start = 1'b1;
      end
    end

    if (start) begin
      key_idx_next = 2'd0;
      if (remaining_next == 64'd0) begin
        phase_next      = wsfd_pkg::PH_HDR1;
        res.valid       = 1'b1;
        res.frame_end   = 1'b1;
        res.empty_frame = 1'b1;
      end else begin
        phase_next = wsfd_pkg::PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= wsfd_pkg::PH_HDR1;
      field_count <= 3'd0;
      fin_flag    <= 1'b0;
      opcode      <= 4'd0;
      masked      <= 1'b0;
      key_idx     <= 2'd0;
      remaining   <= 64'd0;
      mask_key    <= 32'd0;
    end else if (advance) begin
      phase       <= phase_next;
      field_count <= field_count_next;
      fin_flag    <= fin_flag_next;
      opcode      <= opcode_next;
      masked      <= masked_next;
      key_idx     <= key_idx_next;
      remaining   <= remaining_next;
      mask_key    <= mask_key_next;
    end
  end

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == wsfd_pkg::PH_DATA) |-> (remaining != 64'd0))
    else $error("payload phase with no bytes left");

  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.empty_frame) |-> (res.frame_end && res.payload_byte == 8'd0))
    else $error("empty marker must close its frame with zero data");

endmodule

/* sv/websocket_frame_deframer_top.sv */
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side WebSocket frame deframer: bytes in, unmasked payload beats out.
// ---------------------------------------------------------------------------
// Usage:
//   The slave side takes the received connection stream, one byte per beat
//   on s_tdata. Header, extended length and mask key bytes are consumed
//   silently; each payload byte leaves on the master side unmasked, with the
//   frame opcode and FIN bit in m_tuser and m_tlast on the last byte of the
//   frame. A frame with no payload yields one beat with empty_frame set,
//   zero data and m_tlast high.
//   A payload byte is loaded into the output register at the edge that
//   accepts it and shows on the master side right after (one register stage).
//   Throughput: one byte per cycle unless stalled, set by the single state
//   update per byte that feeds the output register.
//   Stall: while a result waits in the output register and m_tready is low,
//   s_tready drops and the parser state holds; a beat is taken again in the
//   same cycle that the waiting result is taken.
//   Reset: rst (synchronous) returns the parser to the first header byte
//   and empties the output register.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tlast,   // frame_end
  output logic [5:0] m_tuser    // [3:0] frame_opcode, [4] final_fragment, [5] empty_frame
);

  wsfd_pkg::result_t res;
  logic              accept;

  // Take a byte whenever the output register is free or drains this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  wsfd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .rx_byte (s_tdata),
    .res     (res)
  );

  // Output register: load on every accepted byte that yields a result, clear when drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tdata <= res.payload_byte;
      m_tlast <= res.frame_end;
      m_tuser <= {res.empty_frame, res.final_fragment, res.frame_opcode};
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while a result is stalled");

  a_load_on_result: assert property (@(posedge clk) disable iff (rst)
    (accept && res.valid) |=> m_tvalid)
    else $error("result lost on its way to the output register");

endmodule
